/* design/crast_pkg.sv */
// ----------------------------------------------------------------------------
// crast_pkg
// Shared types, constants and helper functions of the circle rasterizer.
// ----------------------------------------------------------------------------
package crast_pkg;

    // coordinate wrap width of emitted pixels
    localparam int COORD_BITS = 16;

    // iteration queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // pixel counts of one iteration
    localparam int THIN_PIXELS  = 4;
    localparam int THICK_PIXELS = 36;
    localparam int PIX_CNT_W    = 6;

    // working width of the error walk and pixel sums
    localparam int WALK_W = 18;

    // commands carried in s_tuser
    typedef enum logic {
        CMD_BEGIN   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // configuration register indexes (paddr[2])
    typedef enum logic {
        REG_DRAW_COLOR  = 1'b0,
        REG_THICK_LINES = 1'b1
    } reg_idx_t;

    // one iteration handed from front to back
    typedef struct packed {
        logic signed [14:0] center_col;
        logic signed [14:0] center_row;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic               thick;
        logic               done;
    } iter_t;

    // neighbour column offsets, in emission order
    function automatic logic signed [1:0] nb_dx(input logic [2:0] j);
        logic signed [1:0] d;
        case (j)
            3'd0, 3'd1, 3'd2: d = -2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // neighbour row offsets, in emission order
    function automatic logic signed [1:0] nb_dy(input logic [2:0] j);
        logic signed [1:0] d;
        case (j)
            3'd0, 3'd3, 3'd7: d = -2'sd1;
            3'd1, 3'd6:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // wrap to COORD_BITS two's complement, then take 16 bits
    function automatic logic [15:0] coord_out(input logic signed [WALK_W-1:0] v);
        logic signed [31:0] s;
        s = 32'(v);
        s = (s <<< (32 - COORD_BITS)) >>> (32 - COORD_BITS);
        return s[15:0];
    endfunction

endpackage

/* design/crast_fifo.sv */
// ----------------------------------------------------------------------------
// crast_fifo
// Short queue of iteration records between the walk front and pixel back.
// ----------------------------------------------------------------------------
module crast_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crast_pkg::iter_t push_data,
    input  logic             pop,
    output crast_pkg::iter_t pop_data,
    output logic             full,
    output logic             nonempty
);

    crast_pkg::iter_t                   mem_reg [crast_pkg::QUEUE_DEPTH];
    logic [crast_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [crast_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [crast_pkg::QCNT_W-1:0]       count_reg, count_next;

    localparam logic [crast_pkg::QCNT_W-1:0] DEPTH_C = crast_pkg::QCNT_W'(crast_pkg::QUEUE_DEPTH);
    localparam logic [crast_pkg::QPTR_W-1:0] LAST_C  = crast_pkg::QPTR_W'(crast_pkg::QUEUE_DEPTH - 1);

    assign full     = (count_reg == DEPTH_C);
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/crast_front.sv */
// ----------------------------------------------------------------------------
// crast_front
// Command front: takes begin/advance commands, runs the error-term walk and
// queues one record per active advance.
// ----------------------------------------------------------------------------
module crast_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic               command,
    input  logic signed [14:0] center_x,
    input  logic signed [14:0] center_y,
    input  logic        [13:0] radius_in,
    input  logic               thick_lines,
    input  logic               queue_full,
    output logic               push,
    output crast_pkg::iter_t   push_data
);

    localparam int W = crast_pkg::WALK_W;

    logic signed [14:0]  center_col_reg, center_col_next;
    logic signed [14:0]  center_row_reg, center_row_next;
    logic signed [15:0]  x_offset_reg, x_offset_next;
    logic signed [15:0]  y_offset_reg, y_offset_next;
    logic signed [W-1:0] error_reg, error_next;
    logic                active_reg, active_next;

    logic                accept;
    logic signed [W-1:0] xo, yo, yo1, xo1, e1, e2;
    logic                step_y, step_x;

    assign cmd_ready = !queue_full;
    assign accept    = cmd_valid && cmd_ready;
    assign push      = accept && (command == crast_pkg::CMD_ADVANCE) && active_reg;

    // one walk step: row first, then column
    always_comb
    begin
        xo     = W'(x_offset_reg);
        yo     = W'(y_offset_reg);
        step_y = (error_reg <= yo);
        yo1    = step_y ? yo + W'(1) : yo;
        e1     = step_y ? error_reg + (yo1 <<< 1) + W'(1) : error_reg;
        step_x = (error_reg > xo) || (e1 > yo1);
        xo1    = step_x ? xo + W'(1) : xo;
        e2     = step_x ? e1 + (xo1 <<< 1) + W'(1) : e1;
    end

    // queued record holds the offsets before the step
    always_comb
    begin
        push_data.center_col = center_col_reg;
        push_data.center_row = center_row_reg;
        push_data.x_offset   = x_offset_reg;
        push_data.y_offset   = y_offset_reg;
        push_data.thick      = thick_lines;
        push_data.done       = !xo1[W-1];
    end

    // walk state update
    always_comb
    begin
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        x_offset_next   = x_offset_reg;
        y_offset_next   = y_offset_reg;
        error_next      = error_reg;
        active_next     = active_reg;
        if (accept && (command == crast_pkg::CMD_BEGIN))
        begin
            center_col_next = center_x;
            center_row_next = center_y;
            x_offset_next   = -$signed({2'b00, radius_in});
            y_offset_next   = '0;
            error_next      = W'(2) - $signed({3'b000, radius_in, 1'b0});
            active_next     = 1'b1;
        end
        else if (push)
        begin
            x_offset_next = xo1[15:0];
            y_offset_next = yo1[15:0];
            error_next    = e2;
            active_next   = xo1[W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            x_offset_reg   <= '0;
            y_offset_reg   <= '0;
            error_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            x_offset_reg   <= x_offset_next;
            y_offset_reg   <= y_offset_next;
            error_reg      <= error_next;
            active_reg     <= active_next;
        end
    end

endmodule

/* design/crast_back.sv */
// ----------------------------------------------------------------------------
// crast_back
// Pixel back: expands one queued iteration into 4 or 36 pixels, one per
// cycle into the output register while out_ready does not hold it.
// ----------------------------------------------------------------------------
module crast_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_nonempty,
    input  crast_pkg::iter_t queue_data,
    output logic             pop,
    input  logic [7:0]       draw_color,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      pixel_x,
    output logic [15:0]      pixel_y,
    output logic [7:0]       pixel_color,
    output logic             last_of_step,
    output logic             circle_done
);

    localparam int W  = crast_pkg::WALK_W;
    localparam int CW = crast_pkg::PIX_CNT_W;
    localparam logic [CW-1:0] THIN_LAST  = CW'(crast_pkg::THIN_PIXELS - 1);
    localparam logic [CW-1:0] THICK_LAST = CW'(crast_pkg::THICK_PIXELS - 1);

    crast_pkg::iter_t    iter_reg;
    logic                busy_reg, busy_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [15:0]         pixel_x_reg, pixel_y_reg;
    logic [7:0]          pixel_color_reg;
    logic                last_reg, done_reg;

    logic                load, last_pix, nb_phase;
    logic signed [W-1:0] xo, yo, bx, by, sx, sy;
    logic signed [1:0]   dx, dy;

    assign load     = busy_reg && (!out_valid_reg || out_ready);
    assign last_pix = (cnt_reg == (iter_reg.thick ? THICK_LAST : THIN_LAST));
    assign nb_phase = iter_reg.thick && !cnt_reg[5];
    assign pop      = queue_nonempty && (!busy_reg || (load && last_pix));

    // pick the point of this pixel
    always_comb
    begin
        xo = W'(iter_reg.x_offset);
        yo = W'(iter_reg.y_offset);
        dx = 2'sd0;
        dy = 2'sd0;
        if (nb_phase)
        begin
            bx = (cnt_reg[4:3] == 2'd0 || cnt_reg[4:3] == 2'd1) ? -xo : xo;
            by = (cnt_reg[4:3] == 2'd1 || cnt_reg[4:3] == 2'd2) ? -yo : yo;
            dx = crast_pkg::nb_dx(cnt_reg[2:0]);
            dy = crast_pkg::nb_dy(cnt_reg[2:0]);
        end
        else
        begin
            case (cnt_reg[1:0])
                2'd0:    begin bx = -xo; by = yo;  end
                2'd1:    begin bx = -yo; by = -xo; end
                2'd2:    begin bx = xo;  by = -yo; end
                default: begin bx = yo;  by = xo;  end
            endcase
        end
        sx = W'(iter_reg.center_col) + bx + W'(dx);
        sy = W'(iter_reg.center_row) + by + W'(dy);
    end

    // sequencing of the current iteration
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (load)
        begin
            if (last_pix)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // iteration record and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            iter_reg <= queue_data;
        end
        if (load)
        begin
            pixel_x_reg     <= crast_pkg::coord_out(sx);
            pixel_y_reg     <= crast_pkg::coord_out(sy);
            pixel_color_reg <= draw_color;
            last_reg        <= last_pix;
            done_reg        <= last_pix && iter_reg.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_color  = pixel_color_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

/* design/circle_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// circle_rasterizer_unit
// Error-term circle walk over one quadrant, mirrored to four points.
// ----------------------------------------------------------------------------
// usage
//   s_* carries commands: s_tuser 0 begins a circle (center and radius from
//   s_tdata, no pixels), 1 advances one iteration of the walk.
//   m_* carries pixels: x, y and color in m_tdata, m_tlast on the last pixel
//   of an advance, m_tuser on the last pixel of the whole circle.
//   APB registers: 0x0 draw_color, 0x4 thick_lines; pready is always high.
// throughput
//   one pixel per cycle out of the output register while m_tready is
//   high: 4 pixels per thin advance, 36 per thick one.
//   a 2-entry iteration queue lets advances be taken while pixels drain.
// first pixel path
//   with the queue empty and the pixel expander idle, an advance goes
//   through the iteration queue and iteration register to the output register.
// reset
//   walk idle, queue empty, draw_color 15, thick_lines 0.
// stall
//   while m_tready is low the pixel holds; s_tready drops once the queue
//   is full.
// ----------------------------------------------------------------------------
module circle_rasterizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // center_x[14:0], center_y[29:15], radius_in[43:30]
    input  logic        s_tuser,   // command
    // pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x[15:0], pixel_y[31:16], pixel_color[39:32]
    output logic        m_tlast,   // last_of_step
    output logic        m_tuser,   // circle_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       draw_color_reg;
    logic             thick_lines_reg;
    logic             cfg_write;

    logic             push, pop, queue_full, queue_nonempty;
    crast_pkg::iter_t push_data, pop_data;
    logic [15:0]      pixel_x, pixel_y;
    logic [7:0]       pixel_color;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg  <= 8'd15;
            thick_lines_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (crast_pkg::reg_idx_t'(paddr[2]))
                crast_pkg::REG_DRAW_COLOR:  draw_color_reg  <= pwdata[7:0];
                crast_pkg::REG_THICK_LINES: thick_lines_reg <= pwdata[0];
                default:                    draw_color_reg  <= draw_color_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (crast_pkg::reg_idx_t'(paddr[2]))
            crast_pkg::REG_DRAW_COLOR:  prdata = {24'd0, draw_color_reg};
            crast_pkg::REG_THICK_LINES: prdata = {31'd0, thick_lines_reg};
            default:                    prdata = '0;
        endcase
    end

    crast_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (s_tvalid),
        .cmd_ready   (s_tready),
        .command     (s_tuser),
        .center_x    (s_tdata[14:0]),
        .center_y    (s_tdata[29:15]),
        .radius_in   (s_tdata[43:30]),
        .thick_lines (thick_lines_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    crast_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .nonempty  (queue_nonempty)
    );

    crast_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_nonempty (queue_nonempty),
        .queue_data     (pop_data),
        .pop            (pop),
        .draw_color     (draw_color_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_color    (pixel_color),
        .last_of_step   (m_tlast),
        .circle_done    (m_tuser)
    );

    assign m_tdata = {pixel_color, pixel_y, pixel_x};

endmodule

/* tb/circle_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pixel_checker
// Watches the command, pixel and register channels of the circle rasterizer,
// predicts every pixel of each advance from its own copy of the walk, and
// compares the pixel stream in order, field by field.
// ----------------------------------------------------------------------------
module circle_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // center_x[14:0], center_y[29:15], radius_in[43:30]
    input  logic        s_tuser,   // command
    // pixel stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // pixel_x[15:0], pixel_y[31:16], pixel_color[39:32]
    input  logic        m_tlast,   // last_of_step
    input  logic        m_tuser,   // circle_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // results
    output int          mismatch_count,
    output int          pixels_pending
);

    // one predicted pixel
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  color;
        logic        last_of_step;
        logic        circle_done;
    } pixel_t;

    pixel_t             expected_pixels[$];
    int                 pixel_index;

    // register copies
    logic [7:0]         color_reg;
    logic               thick_reg;

    // walk state
    logic signed [14:0] ctr_col;
    logic signed [14:0] ctr_row;
    logic signed [15:0] walk_x;
    logic signed [15:0] walk_y;
    logic signed [17:0] walk_err;
    logic               walk_on;

    // wrap a coordinate sum to COORD_BITS, then keep 16 bits
    function automatic logic [15:0] wrap_coord(input int v);
        logic [63:0] mask;
        logic [63:0] u;
        mask = (64'd1 << crast_pkg::COORD_BITS) - 64'd1;
        u    = {{32{v[31]}}, v} & mask;
        if (u[crast_pkg::COORD_BITS-1])
            u = u | ~mask;
        return u[15:0];
    endfunction

    // queue one pixel relative to the center
    task automatic plot(input int dx, input int dy);
        pixel_t p;
        p.x            = wrap_coord(int'(ctr_col) + dx);
        p.y            = wrap_coord(int'(ctr_row) + dy);
        p.color        = color_reg;
        p.last_of_step = 1'b0;
        p.circle_done  = 1'b0;
        expected_pixels.push_back(p);
    endtask

    // pixels of the current iteration, then one step of the error walk
    task automatic walk_iteration();
        int     nb_col[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
        int     nb_row[8] = '{-1, 0, 1, -1, 1, 1, 0, -1};
        int     qc[4];
        int     qr[4];
        int     xo;
        int     yo;
        int     e0;
        int     err;
        pixel_t tail;
        xo = walk_x;
        yo = walk_y;
        // neighbours of the four quadrant points first
        if (thick_reg)
        begin
            qc = '{-xo, -xo, xo, xo};
            qr = '{yo, -yo, -yo, yo};
            for (int q = 0; q < 4; q++)
            begin
                for (int j = 0; j < 8; j++)
                    plot(qc[q] + nb_col[j], qr[q] + nb_row[j]);
            end
        end
        plot(-xo, yo);
        plot(-yo, -xo);
        plot(xo, -yo);
        plot(yo, xo);
        // error term update, decisions on the old error and the row-stepped error
        e0  = walk_err;
        err = e0;
        if (e0 <= yo)
        begin
            yo++;
            err += 2 * yo + 1;
        end
        if (e0 > xo || err > yo)
        begin
            xo++;
            err += 2 * xo + 1;
        end
        walk_x   = 16'(xo);
        walk_y   = 16'(yo);
        walk_err = 18'(err);
        // flag the final pixel of this advance
        tail = expected_pixels.pop_back();
        tail.last_of_step = 1'b1;
        if (xo >= 0)
        begin
            walk_on          = 1'b0;
            tail.circle_done = 1'b1;
        end
        expected_pixels.push_back(tail);
    endtask

    task automatic take_command(input crast_pkg::cmd_t cmd, input logic [47:0] data);
        int ri;
        ri = data[43:30];
        if (cmd == crast_pkg::CMD_BEGIN)
        begin
            ctr_col  = data[14:0];
            ctr_row  = data[29:15];
            walk_x   = 16'(-ri);
            walk_y   = '0;
            walk_err = 18'(2 - 2 * ri);
            walk_on  = 1'b1;
        end
        else if (walk_on)
        begin
            walk_iteration();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("pixel %0d: %s got %0d expected %0d", pixel_index, what, got, want);
        mismatch_count++;
    endtask

    // compare one pixel transfer with the oldest prediction
    task automatic check_pixel();
        pixel_t             want;
        logic signed [15:0] got_x;
        logic signed [15:0] got_y;
        got_x = m_tdata[15:0];
        got_y = m_tdata[31:16];
        if (expected_pixels.size() == 0)
        begin
            report_mismatch("pixel with none expected, x", got_x, 0);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (m_tdata[15:0] !== want.x)
                report_mismatch("pixel_x", got_x, $signed(want.x));
            if (m_tdata[31:16] !== want.y)
                report_mismatch("pixel_y", got_y, $signed(want.y));
            if (m_tdata[39:32] !== want.color)
                report_mismatch("pixel_color", m_tdata[39:32], want.color);
            if (m_tlast !== want.last_of_step)
                report_mismatch("last_of_step", m_tlast, want.last_of_step);
            if (m_tuser !== want.circle_done)
                report_mismatch("circle_done", m_tuser, want.circle_done);
        end
        pixel_index++;
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            pixel_index    = 0;
            mismatch_count = 0;
            color_reg      = 8'd15;
            thick_reg      = 1'b0;
            ctr_col        = '0;
            ctr_row        = '0;
            walk_x         = '0;
            walk_y         = '0;
            walk_err       = '0;
            walk_on        = 1'b0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (crast_pkg::reg_idx_t'(paddr[2]))
                    crast_pkg::REG_DRAW_COLOR:  color_reg = pwdata[7:0];
                    crast_pkg::REG_THICK_LINES: thick_reg = pwdata[0];
                    default:                    ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_pixel();
            if (s_tvalid && s_tready)
                take_command(crast_pkg::cmd_t'(s_tuser), s_tdata);
        end
        pixels_pending = expected_pixels.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives commands and register writes into the circle rasterizer with random
// gaps and output stalls; the pixel checker beside the block predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int          GAP_MAX       = 17;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 11;
    localparam logic [14:0] COORD_MIN     = 15'h4000;
    localparam logic [14:0] COORD_MAX     = 15'h3FFF;
    localparam logic [13:0] RADIUS_MAX    = 14'h3FFF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pixels_pending;
    int          commands_sent;
    logic        quiet;
    logic        hold_req;

    circle_rasterizer_unit DUT (.*);

    circle_pixel_checker pixel_check (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // wait cycles before one transfer, none in quiet stretches
    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // one command transfer
    task automatic send_command(input crast_pkg::cmd_t cmd, input logic [14:0] cx,
                                input logic [14:0] cy, input logic [13:0] r);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = cmd;
        s_tdata  = {4'b0000, r, cy, cx};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        commands_sent++;
    endtask

    // advance with random filler in the unused fields
    task automatic advance();
        send_command(crast_pkg::CMD_ADVANCE, 15'($urandom), 15'($urandom), 14'($urandom));
    endtask

    task automatic walk_circle(input logic [14:0] cx, input logic [14:0] cy,
                               input logic [13:0] r, input int steps);
        send_command(crast_pkg::CMD_BEGIN, cx, cy, r);
        repeat (steps) advance();
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_register(input crast_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // let every predicted pixel arrive and the block go quiet
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pixels_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic new_setting(input logic [7:0] color, input logic thick);
        drain();
        write_register(crast_pkg::REG_DRAW_COLOR, {24'd0, color});
        write_register(crast_pkg::REG_THICK_LINES, {31'd0, thick});
    endtask

    // one random command sequence, mostly whole small circles
    task automatic run_sequence();
        int kind;
        int r;
        int steps;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            // small circle, mostly walked to the end and sometimes past it
            r     = $urandom_range(0, 6);
            steps = $urandom_range(r + 1, 2 * r + 2);
        end
        else if (kind < 16)
        begin
            // wide circle walked briefly, then dropped
            r     = $urandom_range(0, 16383);
            steps = $urandom_range(1, 4);
        end
        else if (kind < 18)
        begin
            // broken walk, cut off by the next begin
            r     = $urandom_range(2, 40);
            steps = $urandom_range(0, 2);
        end
        else
        begin
            // stray advance
            advance();
            return;
        end
        walk_circle(15'($urandom), 15'($urandom), 14'(r), steps);
    endtask

    // pixel receiver: random stalls per transfer, one long hold on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("circle_rasterizer_unit verification failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        commands_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, idle advance, radius zero, extremes
        advance();
        walk_circle(15'd0, 15'd0, 14'd0, 1);
        walk_circle(COORD_MIN, COORD_MAX, 14'd1, 3);
        new_setting(8'd255, 1'b1);
        walk_circle(COORD_MAX, COORD_MIN, 14'd0, 1);
        walk_circle(COORD_MAX, COORD_MAX, RADIUS_MAX, 2);
        // begin while a walk is running
        walk_circle(COORD_MIN, COORD_MIN, RADIUS_MAX, 2);
        // thickness changes in the middle of a walk
        new_setting(8'd0, 1'b0);
        advance();
        advance();
        new_setting(8'd128, 1'b1);
        advance();
        walk_circle(15'd100, -15'sd100, 14'd3, 6);

        // random phases over several register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            int stop;
            case (phase)
                0:       new_setting(8'd0, 1'b0);
                1, 3:    new_setting(8'($urandom), 1'b1);
                5:       new_setting(8'd255, 1'b0);
                default: new_setting(8'($urandom), 1'($urandom));
            endcase
            quiet = (phase == 2);
            if (phase == 3)
            begin
                // long output hold while advances keep coming
                hold_req = 1'b1;
                walk_circle(15'($urandom), 15'($urandom), 14'd8, 6);
            end
            stop = commands_sent + PHASE_ITEMS;
            while (commands_sent < stop)
                run_sequence();
        end

        drain();
        if (mismatch_count == 0)
            $display("circle_rasterizer_unit verification clean");
        else
            $display("circle_rasterizer_unit verification failed");
        $finish;
    end

endmodule
